>>> src/cfws_pkg.sv
`timescale 1ns / 1ps

package cfws_pkg;

    // Word width of one queue entry
    localparam int DATA_W = 32;

    // Operation codes carried on the op field
    typedef enum logic [2:0] {
        OP_ENQ  = 3'd0,
        OP_DEQ  = 3'd1,
        OP_PEEK = 3'd2,
        OP_CONT = 3'd3,
        OP_TRAV = 3'd4
    } t_op;

    // Result status codes
    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_OVERFLOW = 2'd1,
        STS_EMPTY    = 2'd2
    } t_status;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_SCAN,
        S_FIN,
        S_TRAV
    } t_state;

    // One result transfer from the controller into the output register
    typedef struct packed {
        logic                     load;
        logic signed [DATA_W-1:0] value;
        t_status                  status;
        logic                     found;
        logic                     last;
    } t_res;

endpackage

>>> src/circular_fifo_with_search.sv
`timescale 1ns / 1ps
// Order: enqueue and empty-queue results go into the output register at the transfer;
//   dequeue/peek read the head entry, then hand it out in S_POP; contains scans, then S_FIN.
// Throughput: enqueue one per cycle while the output is not stalled; other operations stall
//   the input until their last result is out; the entry memory has one registered read port.
// Reset (synchronous, active low) clears head, tail, count and the output valid; the entry
//   memory is not cleared, only entries written by an enqueue are ever read.

module circular_fifo_with_search
    import cfws_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input channel
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [2:0]               i_op,
    input  logic signed [DATA_W-1:0] i_data_value,
    // output channel
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [DATA_W-1:0] o_value,
    output logic [1:0]               o_status,
    output logic                     o_found,
    output logic                     o_last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic                     we;
    logic [AW-1:0]            waddr;
    logic signed [DATA_W-1:0] wdata;
    logic                     re;
    logic [AW-1:0]            raddr;
    logic signed [DATA_W-1:0] rdata;
    t_res                     res;
    logic                     out_free;

    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_value;
    t_status                  r_status;
    logic                     r_found;
    logic                     r_last;

    cfws_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    cfws_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_data_value (i_data_value),
        .i_out_free   (out_free),
        .o_res        (res),
        .o_we         (we),
        .o_waddr      (waddr),
        .o_wdata      (wdata),
        .o_re         (re),
        .o_raddr      (raddr),
        .i_rdata      (rdata)
    );

    // Output register is free when empty or being drained this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.load) begin
            r_value  <= res.value;
            r_status <= res.status;
            r_found  <= res.found;
            r_last   <= res.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_status    = r_status;
    assign o_found     = r_found;
    assign o_last      = r_last;

endmodule

>>> src/cfws_ram.sv
`timescale 1ns / 1ps

module cfws_ram
    import cfws_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  logic signed [DATA_W-1:0] i_wdata,
    input  logic                     i_re,
    input  logic [AW-1:0]            i_raddr,
    output logic signed [DATA_W-1:0] o_rdata
);

    logic signed [DATA_W-1:0] r_mem [DEPTH];
    logic signed [DATA_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/cfws_ctrl.sv
`timescale 1ns / 1ps

module cfws_ctrl
    import cfws_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int CW    = 5
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input channel
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [2:0]               i_op,
    input  logic signed [DATA_W-1:0] i_data_value,
    // output register has room for a transfer this cycle
    input  logic                     i_out_free,
    output t_res                     o_res,
    // memory ports
    output logic                     o_we,
    output logic [AW-1:0]            o_waddr,
    output logic signed [DATA_W-1:0] o_wdata,
    output logic                     o_re,
    output logic [AW-1:0]            o_raddr,
    input  logic signed [DATA_W-1:0] i_rdata
);

    t_state                   r_state, n_state;
    logic [AW-1:0]            r_head, n_head;
    logic [AW-1:0]            r_tail, n_tail;
    logic [CW-1:0]            r_count, n_count;
    logic [AW-1:0]            r_ptr, n_ptr;
    logic [CW-1:0]            r_left, n_left;
    logic signed [DATA_W-1:0] r_key, n_key;
    logic                     r_deq, n_deq;
    logic                     r_hit, n_hit;

    logic idle;
    logic accept;
    logic empty;
    logic full;
    logic at_last;
    logic match;

    // Ring increment with wrap at DEPTH
    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] p);
        if (p == AW'(DEPTH - 1)) begin
            return '0;
        end
        return p + AW'(1);
    endfunction

    assign idle    = (r_state == S_IDLE);
    assign accept  = i_in_valid && idle && i_out_free;
    assign empty   = (r_count == '0);
    assign full    = (r_count == CW'(DEPTH));
    assign at_last = (r_left == CW'(1));
    assign match   = (i_rdata == r_key);

    assign o_in_stall = !(idle && i_out_free);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_op)
                        OP_DEQ, OP_PEEK: n_state = empty ? S_IDLE : S_POP;
                        OP_CONT:         n_state = empty ? S_IDLE : S_SCAN;
                        OP_TRAV:         n_state = empty ? S_IDLE : S_TRAV;
                        default:         n_state = S_IDLE;
                    endcase
                end
            end
            S_POP: begin
                if (i_out_free) n_state = S_IDLE;
            end
            S_SCAN: begin
                if (match || at_last) n_state = S_FIN;
            end
            S_FIN: begin
                if (i_out_free) n_state = S_IDLE;
            end
            S_TRAV: begin
                if (i_out_free && at_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs and datapath updates
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_ptr   = r_ptr;
        n_left  = r_left;
        n_key   = r_key;
        n_deq   = r_deq;
        n_hit   = r_hit;
        o_we    = 1'b0;
        o_waddr = r_tail;
        o_wdata = i_data_value;
        o_re    = 1'b0;
        o_raddr = r_head;
        o_res   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_op)
                        OP_ENQ: begin
                            o_res.load = 1'b1;
                            o_res.last = 1'b1;
                            if (full) begin
                                o_res.status = STS_OVERFLOW;
                            end else begin
                                o_res.status = STS_OK;
                                o_we         = 1'b1;
                                n_tail       = f_next(r_tail);
                                n_count      = r_count + CW'(1);
                            end
                        end
                        OP_DEQ, OP_PEEK: begin
                            if (empty) begin
                                o_res.load   = 1'b1;
                                o_res.status = STS_EMPTY;
                                o_res.last   = 1'b1;
                            end else begin
                                o_re  = 1'b1;
                                n_deq = (i_op == OP_DEQ);
                            end
                        end
                        OP_CONT: begin
                            if (empty) begin
                                o_res.load   = 1'b1;
                                o_res.status = STS_OK;
                                o_res.last   = 1'b1;
                            end else begin
                                o_re   = 1'b1;
                                n_ptr  = r_head;
                                n_left = r_count;
                                n_key  = i_data_value;
                            end
                        end
                        OP_TRAV: begin
                            if (empty) begin
                                o_res.load   = 1'b1;
                                o_res.status = STS_EMPTY;
                                o_res.last   = 1'b1;
                            end else begin
                                o_re   = 1'b1;
                                n_ptr  = r_head;
                                n_left = r_count;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // head entry is on the read data; hand it out
            S_POP: begin
                if (i_out_free) begin
                    o_res.load   = 1'b1;
                    o_res.value  = i_rdata;
                    o_res.status = STS_OK;
                    o_res.last   = 1'b1;
                    if (r_deq) begin
                        n_head  = f_next(r_head);
                        n_count = r_count - CW'(1);
                    end
                end
            end
            // compare one entry per cycle, read the next one meanwhile
            S_SCAN: begin
                n_hit = match;
                if (!match && !at_last) begin
                    o_re    = 1'b1;
                    o_raddr = f_next(r_ptr);
                    n_ptr   = f_next(r_ptr);
                    n_left  = r_left - CW'(1);
                end
            end
            S_FIN: begin
                if (i_out_free) begin
                    o_res.load   = 1'b1;
                    o_res.status = STS_OK;
                    o_res.found  = r_hit;
                    o_res.last   = 1'b1;
                end
            end
            // one live entry per transfer, oldest first
            S_TRAV: begin
                if (i_out_free) begin
                    o_res.load   = 1'b1;
                    o_res.value  = i_rdata;
                    o_res.status = STS_OK;
                    o_res.last   = at_last;
                    if (!at_last) begin
                        o_re    = 1'b1;
                        o_raddr = f_next(r_ptr);
                        n_ptr   = f_next(r_ptr);
                        n_left  = r_left - CW'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // Per-operation working registers
    always_ff @(posedge i_clk) begin
        r_ptr  <= n_ptr;
        r_left <= n_left;
        r_key  <= n_key;
        r_deq  <= n_deq;
        r_hit  <= n_hit;
    end

    // Occupancy never passes the capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above capacity");

    // Memory is written only when there is room
    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_we |-> (!full && idle))
        else $error("write into a full queue");

    // A completed dequeue removes exactly one entry
    a_deq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP && i_out_free && r_deq)
            |=> (r_count == CW'($past(r_count) - CW'(1))))
        else $error("dequeue did not drop the count by one");

    // Scan and traversal reads stay within the live entries
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_re && !idle) |-> (r_left > CW'(1)))
        else $error("read past the last live entry");

endmodule

>>> tb/cfws_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the FIFO, keeps a queue of the expected results and
// compares every output transfer against the oldest one.
module cfws_checker
    import cfws_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input channel, observed
    input  logic                     i_in_valid,
    input  logic                     i_in_stall,
    input  logic [2:0]               i_op,
    input  logic signed [DATA_W-1:0] i_data_value,
    // output channel, observed
    input  logic                     i_out_valid,
    input  logic                     i_out_stall,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic [1:0]               i_status,
    input  logic                     i_found,
    input  logic                     i_last,
    // to the top
    output int                       o_errors,
    output int                       o_pending
);

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        t_status                  status;
        logic                     found;
        logic                     last;
    } t_fifo_result;

    // Live queue contents, oldest at index 0
    logic signed [DATA_W-1:0] held_words[$];
    // Results still owed by the block, oldest first
    t_fifo_result             owed_results[$];
    int                       error_count = 0;

    task automatic flag_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        error_count++;
    endtask

    // Apply one accepted operation to the shadow queue and queue its results
    task automatic apply_queue_op(input logic [2:0] op, input logic signed [DATA_W-1:0] word);
        t_fifo_result res;
        int           n_live;
        res.value  = '0;
        res.status = STS_OK;
        res.found  = 1'b0;
        res.last   = 1'b1;
        n_live     = held_words.size();
        case (op)
            OP_ENQ: begin
                if (n_live >= DEPTH)
                    res.status = STS_OVERFLOW;
                else
                    held_words.push_back(word);
                owed_results.push_back(res);
            end
            OP_DEQ, OP_PEEK: begin
                if (n_live == 0) begin
                    res.status = STS_EMPTY;
                end else begin
                    res.value = held_words[0];
                    if (op == OP_DEQ)
                        void'(held_words.pop_front());
                end
                owed_results.push_back(res);
            end
            OP_CONT: begin
                foreach (held_words[k])
                    if (held_words[k] == word)
                        res.found = 1'b1;
                owed_results.push_back(res);
            end
            OP_TRAV: begin
                if (n_live == 0) begin
                    res.status = STS_EMPTY;
                    owed_results.push_back(res);
                end else begin
                    for (int k = 0; k < n_live; k++) begin
                        res.value = held_words[k];
                        res.last  = (k == n_live - 1);
                        owed_results.push_back(res);
                    end
                end
            end
            default: ; // spare codes: no result, no change
        endcase
    endtask

    // Compare one output transfer field by field
    task automatic check_transfer();
        t_fifo_result want;
        if (owed_results.size() == 0) begin
            flag_mismatch("result transfer with nothing expected");
            return;
        end
        want = owed_results.pop_front();
        if (i_value !== want.value)
            flag_mismatch($sformatf("value got %0d want %0d", i_value, want.value));
        if (i_status !== want.status)
            flag_mismatch($sformatf("status got %0d want %0d", i_status, want.status));
        if (i_found !== want.found)
            flag_mismatch($sformatf("found got %b want %b", i_found, want.found));
        if (i_last !== want.last)
            flag_mismatch($sformatf("last got %b want %b", i_last, want.last));
    endtask

    // Sample both channels at the clock edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall)
                check_transfer();
            if (i_in_valid && !i_in_stall)
                apply_queue_op(i_op, i_data_value);
        end
        o_pending <= owed_results.size();
        o_errors  <= error_count;
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import cfws_pkg::*;

    localparam int DEPTH        = 16;
    localparam int RAND_ITEMS   = 350;
    localparam int QUIET_ITEMS  = 50;     // final stretch without idling
    localparam int DRAIN_CYCLES = 40;     // covers a full traverse or scan
    localparam int CYCLE_LIMIT  = 400000;

    // Op codes the block ignores
    localparam logic [2:0] OP_SPARE5 = 3'd5;
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;

    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     i_in_valid   = 1'b0;
    logic [2:0]               i_op         = OP_ENQ;
    logic signed [DATA_W-1:0] i_data_value = '0;
    logic                     i_out_stall  = 1'b0;
    logic                     o_in_stall;
    logic                     o_out_valid;
    logic signed [DATA_W-1:0] o_value;
    logic [1:0]               o_status;
    logic                     o_found;
    logic                     o_last;
    int                       errors;
    int                       pending;

    logic                     quiet   = 1'b0;
    int                       gap_pct = 20;

    // Recently enqueued words, so searches hit often
    logic signed [DATA_W-1:0] recent_words[DEPTH];
    int                       recent_wr = 0;
    int                       recent_n  = 0;

    always #5 i_clk = ~i_clk;

    circular_fifo_with_search #(
        .DEPTH(DEPTH)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_data_value(i_data_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_value     (o_value),
        .o_status    (o_status),
        .o_found     (o_found),
        .o_last      (o_last)
    );

    cfws_checker #(
        .DEPTH(DEPTH)
    ) u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_data_value(i_data_value),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_value     (o_value),
        .i_status    (o_status),
        .i_found     (o_found),
        .i_last      (o_last),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // Receiver stalls: bursts of random length, at a rate picked from 0, 10, 30 or 60 percent
    int stall_left = 0;
    int stall_pct  = 0;
    int stall_cyc  = 0;
    always @(posedge i_clk) begin
        stall_cyc <= stall_cyc + 1;
        if (stall_cyc % 64 == 0) begin
            case ($urandom_range(3))
                0: stall_pct <= 0;
                1: stall_pct <= 10;
                2: stall_pct <= 30;
                default: stall_pct <= 60;
            endcase
        end
        if (quiet) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if ($urandom_range(99) < stall_pct) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(9);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Watchdog
    int cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Present one operation, hold it until the transfer, then maybe go idle
    task automatic send_op(input logic [2:0] op, input logic signed [DATA_W-1:0] word);
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_data_value <= word;
        if (op == OP_ENQ) begin
            recent_words[recent_wr] = word;
            recent_wr = (recent_wr + 1) % DEPTH;
            if (recent_n < DEPTH)
                recent_n++;
        end
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        if (!quiet && $urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [DATA_W-1:0] pick_word();
        case ($urandom_range(9))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return '0;
            3: return '1;
            4: return $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    // Half the searches look for a word that was recently enqueued
    function automatic logic signed [DATA_W-1:0] search_word();
        if (recent_n > 0 && $urandom_range(1) == 1)
            return recent_words[$urandom_range(recent_n - 1)];
        return pick_word();
    endfunction

    // Op mix per phase: 0 fills, 1 drains, 2 mixes
    function automatic logic [2:0] pick_op(input int kind);
        int r;
        int t_enq, t_deq, t_peek, t_cont, t_trav;
        r = $urandom_range(99);
        case (kind)
            0:       begin t_enq = 70; t_deq = 78; t_peek = 84; t_cont = 92; t_trav = 97; end
            1:       begin t_enq = 15; t_deq = 65; t_peek = 75; t_cont = 85; t_trav = 96; end
            default: begin t_enq = 35; t_deq = 60; t_peek = 70; t_cont = 82; t_trav = 96; end
        endcase
        if (r < t_enq)  return OP_ENQ;
        if (r < t_deq)  return OP_DEQ;
        if (r < t_peek) return OP_PEEK;
        if (r < t_cont) return OP_CONT;
        if (r < t_trav) return OP_TRAV;
        case ($urandom_range(2))
            0:       return OP_SPARE5;
            1:       return OP_SPARE6;
            default: return OP_SPARE7;
        endcase
    endfunction

    initial begin
        int                       sent;
        int                       phase_len;
        int                       kind;
        logic [2:0]               op;
        logic signed [DATA_W-1:0] word;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty queue: underflow on reads, no hit, empty traverse
        send_op(OP_DEQ, '0);
        send_op(OP_PEEK, '0);
        send_op(OP_CONT, 32'sh12345678);
        send_op(OP_TRAV, '0);
        // Spare codes are dropped
        send_op(OP_SPARE5, '1);
        send_op(OP_SPARE6, 32'sh80000000);
        send_op(OP_SPARE7, 32'sh7FFFFFFF);
        // Fill to the brim, extremes first, then overflow
        for (int k = 0; k < DEPTH; k++) begin
            case (k)
                0:       word = 32'sh7FFFFFFF;
                1:       word = 32'sh80000000;
                2:       word = '0;
                3:       word = '1;
                default: word = $urandom;
            endcase
            send_op(OP_ENQ, word);
        end
        send_op(OP_ENQ, 32'sh5A5A5A5A);
        send_op(OP_TRAV, '0);
        send_op(OP_CONT, 32'sh80000000);
        send_op(OP_CONT, 32'sh5A5A5A5A);
        send_op(OP_DEQ, '0);
        send_op(OP_PEEK, '0);

        // Random phases; spare codes do not count toward the total
        sent = 0;
        while (sent < RAND_ITEMS) begin
            kind      = $urandom_range(2);
            phase_len = $urandom_range(10, 40);
            case ($urandom_range(2))
                0:       gap_pct = 0;
                1:       gap_pct = 10;
                default: gap_pct = 35;
            endcase
            for (int k = 0; k < phase_len && sent < RAND_ITEMS; k++) begin
                if (sent == RAND_ITEMS - QUIET_ITEMS)
                    quiet <= 1'b1;
                op   = pick_op(kind);
                word = (op == OP_CONT) ? search_word() : pick_word();
                send_op(op, word);
                if (op <= OP_TRAV)
                    sent++;
            end
        end

        // Let every owed result arrive, then a short drain
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
